/* hw/rtl/pfq_pkg.sv */
package pfq_pkg;

  localparam int unsigned IdWidth   = 4;
  localparam int unsigned PrioWidth = 8;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] MODE_PRIO = 2'd0;
  localparam logic [1:0] MODE_FIFO = 2'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MODE  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } state_t;

  // Contents of one queue slot.
  typedef struct packed {
    logic                        valid;
    logic [IdWidth-1:0]          id;
    logic signed [PrioWidth-1:0] prio;
  } slot_t;

  // Command broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic                        do_ins;
    logic                        do_rem;
    logic                        fifo;
    logic [IdWidth-1:0]          id;
    logic signed [PrioWidth-1:0] prio;
  } cell_cmd_t;

endpackage

/* hw/rtl/pfq_cell.sv */
module pfq_cell (
  input  logic              clk,
  input  logic              rst,
  input  pfq_pkg::cell_cmd_t cmd,
  input  pfq_pkg::slot_t    left,
  input  pfq_pkg::slot_t    right,
  input  logic              ins_before_in,
  output logic              ins_before_out,
  input  logic              match_upto_in,
  output logic              match_upto_out,
  output logic              match,
  output pfq_pkg::slot_t    slot
);
  import pfq_pkg::*;

  logic lower;
  logic ins_here;

  assign match = slot.valid && (slot.id == cmd.id);
  // In priority mode an occupied slot of strictly lower priority, or the first free slot, is where
  // a new entry lands; the carry chain picks the first such cell.
  assign lower          = slot.valid && !cmd.fifo && (slot.prio < cmd.prio);
  assign ins_here       = lower || !slot.valid;
  assign ins_before_out = ins_before_in || ins_here;
  assign match_upto_out = match_upto_in || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (cmd.do_ins) begin
      if (ins_before_in) begin
        slot <= left;
      end else if (ins_here) begin
        slot <= '{valid: 1'b1, id: cmd.id, prio: cmd.prio};
      end
    end else if (cmd.do_rem) begin
      if (match_upto_out) begin
        slot <= right;
      end
    end
  end

endmodule

/* hw/rtl/priority_fifo_ready_queue.sv */
// Ready queue of up to QUEUE_DEPTH entry ids held in a row of slot cells, head
// in cell 0. A transaction is accepted when start is high and busy is low; busy
// then stays high for the execute cycle, in which every cell compares the request
// against its slot and, on success, the row shifts by one place to open or close a gap. The
// result appears with done for exactly one cycle, registered from the execute
// state, and the receiver cannot stall it. A new transaction may be accepted in
// the cycle that done is shown, but not while busy, so a transaction is only
// taken once the cell row is through with the last one.
module priority_fifo_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type,
  input  logic [pfq_pkg::IdWidth-1:0]          entry_id,
  input  logic signed [pfq_pkg::PrioWidth-1:0] entry_priority,
  input  logic [1:0]                           insert_mode,
  output logic                                 done,
  output logic [2:0]                           status,
  output logic                                 head_valid,
  output logic [pfq_pkg::IdWidth-1:0]          head_id,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     entry_count
);
  import pfq_pkg::*;

  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  logic                        req_q;
  logic [IdWidth-1:0]          id_q;
  logic signed [PrioWidth-1:0] prio_q;
  logic [1:0]                  mode_q;

  logic [CntWidth-1:0] cnt;
  status_t             status_q, status_next;
  logic                done_q;

  cell_cmd_t cmd;
  slot_t     slots [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] ins_chain;
  logic [QUEUE_DEPTH:0] match_chain;
  logic [QUEUE_DEPTH-1:0] slot_hits;
  logic found;
  logic full;
  logic exec;

  assign exec  = (state == FSM_EXEC);
  assign busy  = exec;
  assign found = |slot_hits;
  assign full  = (cnt == CntWidth'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: if (start) state_next = FSM_EXEC;
      FSM_EXEC: state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q  <= req_type;
      id_q   <= entry_id;
      prio_q <= entry_priority;
      mode_q <= insert_mode;
    end
  end

  always_comb begin
    status_next = ST_OK;
    if (req_q == REQ_INSERT) begin
      if (mode_q != MODE_PRIO && mode_q != MODE_FIFO) begin
        status_next = ST_BAD_MODE;
      end else if (found) begin
        status_next = ST_DUPLICATE;
      end else if (full) begin
        status_next = ST_FULL;
      end
    end else if (!found) begin
      status_next = ST_NOT_FOUND;
    end
  end

  always_comb begin
    cmd.do_ins = exec && (req_q == REQ_INSERT) && (status_next == ST_OK);
    cmd.do_rem = exec && (req_q == REQ_REMOVE) && (status_next == ST_OK);
    cmd.fifo   = (mode_q == MODE_FIFO);
    cmd.id     = id_q;
    cmd.prio   = prio_q;
  end

  assign ins_chain[0]   = 1'b0;
  assign match_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left_s, right_s;
    if (i == 0) begin : g_first
      assign left_s = '0;
    end else begin : g_mid_l
      assign left_s = slots[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_mid_r
      assign right_s = slots[i+1];
    end

    pfq_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .left           (left_s),
      .right          (right_s),
      .ins_before_in  (ins_chain[i]),
      .ins_before_out (ins_chain[i+1]),
      .match_upto_in  (match_chain[i]),
      .match_upto_out (match_chain[i+1]),
      .match          (slot_hits[i]),
      .slot           (slots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= exec;
      if (cmd.do_ins) begin
        cnt <= cnt + CntWidth'(1);
      end else if (cmd.do_rem) begin
        cnt <= cnt - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_q <= status_next;
    end
  end

  assign done        = done_q;
  assign status      = status_q;
  assign head_valid  = slots[0].valid;
  assign head_id     = slots[0].valid ? slots[0].id : '0;
  assign entry_count = cnt;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntWidth'(QUEUE_DEPTH))
    else $error("entry count exceeds depth");

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    slots[0].valid == (cnt != '0))
    else $error("head slot valid disagrees with entry count");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an execute cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OK) && (req_q == REQ_INSERT) |-> cnt == $past(cnt) + CntWidth'(1))
    else $error("successful insert did not grow the queue");

  a_last_cell_full: assert property (@(posedge clk) disable iff (rst)
    slots[QUEUE_DEPTH-1].valid == full)
    else $error("tail cell valid disagrees with full flag");

endmodule

/* bench/tb_priority_fifo_ready_queue.sv */
`timescale 1ns / 1ps

module tb_priority_fifo_ready_queue;
  import pfq_pkg::*;

  localparam int Depth      = 16;
  localparam int CountWidth = $clog2(Depth + 1);
  localparam int NumIds     = 1 << IdWidth;

  // Insert modes that the block must reject.
  localparam logic [1:0] MODE_RSVD2 = 2'd2;
  localparam logic [1:0] MODE_RSVD3 = 2'd3;

  localparam int NumDirected    = 23;
  localparam int ItemsPerPhase  = 176;

  typedef struct packed {
    status_t               status;
    logic                  head_valid;
    logic [IdWidth-1:0]    head_id;
    logic [CountWidth-1:0] count;
  } outcome_t;

  typedef struct packed {
    logic                        req;
    logic [IdWidth-1:0]          id;
    logic signed [PrioWidth-1:0] prio;
    logic [1:0]                  mode;
    bit                          typed;
    outcome_t                    want;
  } script_row_t;

  localparam outcome_t Untyped = '{ST_OK, 1'b0, 0, 0};

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic                        req_type;
  logic [IdWidth-1:0]          entry_id;
  logic signed [PrioWidth-1:0] entry_priority;
  logic [1:0]                  insert_mode;
  logic                        done;
  logic [2:0]                  status;
  logic                        head_valid;
  logic [IdWidth-1:0]          head_id;
  logic [CountWidth-1:0]       entry_count;

  priority_fifo_ready_queue #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .entry_id      (entry_id),
    .entry_priority(entry_priority),
    .insert_mode   (insert_mode),
    .done          (done),
    .status        (status),
    .head_valid    (head_valid),
    .head_id       (head_id),
    .entry_count   (entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the slot row, head in slot 0.
  logic [IdWidth-1:0]          shadow_ids  [Depth];
  logic signed [PrioWidth-1:0] shadow_prio [Depth];
  int                          shadow_count = 0;

  outcome_t    outcome_fifo[$];
  script_row_t script [NumDirected];
  int          mismatches      = 0;
  int          requests_sent   = 0;
  int          results_checked = 0;
  int          full_hits       = 0;
  int          status_seen [8] = '{default: 0};
  bit          filling         = 1'b1;

  function automatic int slot_of(logic [IdWidth-1:0] id);
    int i;
    for (i = 0; i < shadow_count; i++) begin
      if (shadow_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow row and returns the result it should give.
  function automatic outcome_t apply_request(logic r, logic [IdWidth-1:0] id,
                                             logic signed [PrioWidth-1:0] p,
                                             logic [1:0] m);
    outcome_t o;
    int       pos;
    int       at;
    int       i;
    o.status = ST_OK;
    pos = slot_of(id);
    if (r == REQ_INSERT) begin
      if (m != MODE_PRIO && m != MODE_FIFO) begin
        o.status = ST_BAD_MODE;
      end else if (pos >= 0) begin
        o.status = ST_DUPLICATE;
      end else if (shadow_count >= Depth) begin
        o.status = ST_FULL;
      end else begin
        at = shadow_count;
        if (m == MODE_PRIO) begin
          // Goes ahead of the first strictly lower priority, so ties keep arrival order.
          for (i = 0; i < shadow_count; i++) begin
            if (shadow_prio[i] < p) begin
              at = i;
              break;
            end
          end
        end
        for (i = shadow_count; i > at; i--) begin
          shadow_ids[i]  = shadow_ids[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_ids[at]  = id;
        shadow_prio[at] = p;
        shadow_count++;
        if (shadow_count == Depth) full_hits++;
      end
    end else begin
      if (pos < 0) begin
        o.status = ST_NOT_FOUND;
      end else begin
        for (i = pos; i + 1 < shadow_count; i++) begin
          shadow_ids[i]  = shadow_ids[i+1];
          shadow_prio[i] = shadow_prio[i+1];
        end
        shadow_count--;
      end
    end
    o.head_valid = (shadow_count > 0);
    o.head_id    = (shadow_count > 0) ? shadow_ids[0] : '0;
    o.count      = CountWidth'(shadow_count);
    return o;
  endfunction

  // Drives one transaction and holds it until the block takes it.
  task automatic send_request(logic r, logic [IdWidth-1:0] id,
                              logic signed [PrioWidth-1:0] p, logic [1:0] m,
                              bit typed, outcome_t typed_want);
    outcome_t predicted;
    req_type       <= r;
    entry_id       <= id;
    entry_priority <= p;
    insert_mode    <= m;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_request(r, id, p, m);
    outcome_fifo.push_back(typed ? typed_want : predicted);
    requests_sent++;
  endtask

  task automatic sender_pause(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [IdWidth-1:0] absent_id();
    logic [IdWidth-1:0] cand;
    int                 n;
    cand = IdWidth'($urandom);
    for (n = 0; n < NumIds; n++) begin
      if (slot_of(cand) < 0) return cand;
      cand = cand + 1'b1;
    end
    return cand;
  endfunction

  // Mostly well-formed traffic that sweeps the queue between empty and full,
  // with duplicates, absent ids and rejected modes mixed in.
  task automatic random_request(int idle_pct);
    logic                        r;
    logic [IdWidth-1:0]          id;
    logic signed [PrioWidth-1:0] p;
    logic [1:0]                  m;
    int                          roll;
    if (shadow_count == Depth) filling = 1'b0;
    else if (shadow_count == 0) filling = 1'b1;
    roll = $urandom_range(99);
    r = (filling ? (roll >= 70) : (roll < 70)) ? REQ_REMOVE : REQ_INSERT;
    if ($urandom_range(1) == 1) p = PrioWidth'($urandom);
    else p = PrioWidth'($urandom_range(4)) - PrioWidth'(2);
    if (r == REQ_INSERT) begin
      if ($urandom_range(9) == 0) m = 2'($urandom_range(3, 2));
      else m = ($urandom_range(1) == 0) ? MODE_PRIO : MODE_FIFO;
      if (shadow_count < NumIds && $urandom_range(4) != 0) id = absent_id();
      else id = IdWidth'($urandom);
    end else begin
      m = 2'($urandom);
      if (shadow_count > 0 && $urandom_range(4) != 0) begin
        id = shadow_ids[$urandom_range(shadow_count - 1)];
      end else begin
        id = IdWidth'($urandom);
      end
    end
    send_request(r, id, p, m, 1'b0, Untyped);
    sender_pause(idle_pct);
  endtask

  task automatic compare_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (outcome_fifo.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, status %0d head %0d/%0d count %0d",
                 $time, status, head_valid, head_id, entry_count);
      end else begin
        want = outcome_fifo.pop_front();
        compare_field("status", 8'(want.status), 8'(status));
        compare_field("head_valid", 8'(want.head_valid), 8'(head_valid));
        compare_field("head_id", 8'(want.head_id), 8'(head_id));
        compare_field("entry_count", 8'(want.count), 8'(entry_count));
        status_seen[want.status]++;
        results_checked++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int k;
    int phase;
    int n;
    int drain;
    int idle_plan [3];

    rst            = 1'b1;
    start          = 1'b0;
    req_type       = REQ_INSERT;
    entry_id       = '0;
    entry_priority = '0;
    insert_mode    = MODE_PRIO;

    script = '{
      '{REQ_REMOVE, 4'd5,  8'sd127,  MODE_RSVD3, 1'b1, '{ST_NOT_FOUND, 1'b0, 0, 0}},
      '{REQ_INSERT, 4'd6,  8'sd0,    MODE_RSVD2, 1'b1, '{ST_BAD_MODE, 1'b0, 0, 0}},
      '{REQ_INSERT, 4'd6,  8'sd0,    MODE_RSVD3, 1'b1, '{ST_BAD_MODE, 1'b0, 0, 0}},
      '{REQ_INSERT, 4'd0,  -8'sd128, MODE_PRIO,  1'b1, '{ST_OK, 1'b1, 0, 1}},
      '{REQ_INSERT, 4'd15, 8'sd127,  MODE_PRIO,  1'b1, '{ST_OK, 1'b1, 15, 2}},
      '{REQ_INSERT, 4'd7,  8'sd127,  MODE_PRIO,  1'b1, '{ST_OK, 1'b1, 15, 3}},
      '{REQ_INSERT, 4'd3,  8'sd127,  MODE_FIFO,  1'b1, '{ST_OK, 1'b1, 15, 4}},
      '{REQ_INSERT, 4'd7,  8'sd5,    MODE_PRIO,  1'b1, '{ST_DUPLICATE, 1'b1, 15, 4}},
      '{REQ_INSERT, 4'd7,  8'sd0,    MODE_RSVD2, 1'b1, '{ST_BAD_MODE, 1'b1, 15, 4}},
      '{REQ_INSERT, 4'd9,  -8'sd128, MODE_PRIO,  1'b0, Untyped},
      '{REQ_INSERT, 4'd12, 8'sd0,    MODE_PRIO,  1'b0, Untyped},
      '{REQ_INSERT, 4'd1,  8'sd127,  MODE_PRIO,  1'b0, Untyped},
      '{REQ_REMOVE, 4'd15, 8'sd0,    MODE_PRIO,  1'b1, '{ST_OK, 1'b1, 7, 6}},
      '{REQ_REMOVE, 4'd15, 8'sd0,    MODE_PRIO,  1'b1, '{ST_NOT_FOUND, 1'b1, 7, 6}},
      '{REQ_REMOVE, 4'd9,  8'sd0,    MODE_PRIO,  1'b0, Untyped},
      '{REQ_REMOVE, 4'd12, 8'sd0,    MODE_FIFO,  1'b0, Untyped},
      '{REQ_INSERT, 4'd10, -8'sd1,   MODE_FIFO,  1'b0, Untyped},
      '{REQ_REMOVE, 4'd7,  8'sd0,    MODE_PRIO,  1'b0, Untyped},
      '{REQ_REMOVE, 4'd1,  8'sd0,    MODE_PRIO,  1'b0, Untyped},
      '{REQ_REMOVE, 4'd0,  8'sd0,    MODE_PRIO,  1'b0, Untyped},
      '{REQ_REMOVE, 4'd3,  8'sd0,    MODE_PRIO,  1'b0, Untyped},
      '{REQ_REMOVE, 4'd10, 8'sd0,    MODE_PRIO,  1'b1, '{ST_OK, 1'b0, 0, 0}},
      '{REQ_REMOVE, 4'd10, -8'sd1,   MODE_RSVD3, 1'b1, '{ST_NOT_FOUND, 1'b0, 0, 0}}
    };

    // The receiver cannot stall results, so only the sender side idles.
    idle_plan = '{0, 87, 6};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < NumDirected; k++) begin
      send_request(script[k].req, script[k].id, script[k].prio, script[k].mode,
                   script[k].typed, script[k].want);
    end

    for (phase = 0; phase < 3; phase++) begin
      for (n = 0; n < ItemsPerPhase; n++) begin
        random_request(idle_plan[phase]);
      end
    end
    start <= 1'b0;

    drain = 0;
    while (outcome_fifo.size() != 0 && drain < 50) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (outcome_fifo.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, outcome_fifo.size());
    end

    // With as many ids as slots a full queue turns every insert with a valid mode into a duplicate.
    $display("Sent %0d transactions (%0d scripted), checked %0d results, queue full %0d times.",
             requests_sent, NumDirected, results_checked, full_hits);
    $display("Outcomes: ok %0d, bad mode %0d, not found %0d, duplicate %0d, full %0d.",
             status_seen[ST_OK], status_seen[ST_BAD_MODE], status_seen[ST_NOT_FOUND],
             status_seen[ST_DUPLICATE], status_seen[ST_FULL]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
